// ----- src/fct_pkg.sv -----
package fct_pkg;

  localparam int unsigned FieldWidth = 32;
  localparam int unsigned CornerCount = 8;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_POINT  = 2'd1,
    CMD_SPHERE = 2'd2,
    CMD_BOX    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]                   command;
    logic [2:0]                   plane_index;
    logic signed [FieldWidth-1:0] vec_x;
    logic signed [FieldWidth-1:0] vec_y;
    logic signed [FieldWidth-1:0] vec_z;
    logic signed [FieldWidth-1:0] vec_w;
    logic signed [FieldWidth-1:0] max_x;
    logic signed [FieldWidth-1:0] max_y;
    logic signed [FieldWidth-1:0] max_z;
  } req_t;

  typedef struct packed {
    logic       inside_res;
    logic [1:0] test_kind;
  } rsp_t;

  typedef struct packed {
    logic [FieldWidth-1:0] a;
    logic [FieldWidth-1:0] b;
    logic [FieldWidth-1:0] c;
    logic [FieldWidth-1:0] d;
  } plane_t;

  typedef struct packed {
    logic [CornerCount-1:0] pos;
    logic [CornerCount-1:0] nneg;
  } flags_t;

endpackage

// ----- src/fct_plane_store.sv -----
module fct_plane_store #(
  parameter int unsigned PLANE_COUNT = 6
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [2:0]      idx_i,
  input  fct_pkg::plane_t plane_i,
  output fct_pkg::plane_t planes_o [PLANE_COUNT]
);
  import fct_pkg::*;

  plane_t planes_q [PLANE_COUNT];

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      if (we_i && (idx_i == 3'(p))) begin
        planes_q[p] <= plane_i;
      end
    end
  end

  assign planes_o = planes_q;

endmodule

// ----- src/fct_plane_eval.sv -----
module fct_plane_eval #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic            clk_i,
  input  fct_pkg::plane_t plane_i,
  input  fct_pkg::req_t   req_i,
  output fct_pkg::flags_t flags_o
);
  import fct_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned PW = 2 * CW;
  localparam int unsigned DW = CW + 1 + FRAC_BITS;
  localparam int unsigned SW = ((PW > DW) ? PW : DW) + 3;

  logic signed [CW-1:0] coef [3];
  logic signed [CW-1:0] lo   [3];
  logic signed [CW-1:0] hi   [3];
  logic signed [CW-1:0] d_c;
  logic signed [CW-1:0] r_c;
  logic signed [CW:0]   dsum_d;

  logic signed [PW-1:0] plo_q [3];
  logic signed [PW-1:0] phi_q [3];
  logic signed [CW:0]   dsum_q;
  logic signed [SW-1:0] xy_q  [4];
  logic signed [SW-1:0] zd_q  [2];
  flags_t               flags_q;

  assign coef[0] = plane_i.a[CW-1:0];
  assign coef[1] = plane_i.b[CW-1:0];
  assign coef[2] = plane_i.c[CW-1:0];
  assign d_c     = plane_i.d[CW-1:0];
  assign lo[0]   = req_i.vec_x[CW-1:0];
  assign lo[1]   = req_i.vec_y[CW-1:0];
  assign lo[2]   = req_i.vec_z[CW-1:0];
  assign hi[0]   = req_i.max_x[CW-1:0];
  assign hi[1]   = req_i.max_y[CW-1:0];
  assign hi[2]   = req_i.max_z[CW-1:0];
  assign r_c     = req_i.vec_w[CW-1:0];

  always_comb begin
    dsum_d = (CW+1)'(d_c);
    if (req_i.command == CMD_SPHERE) begin
      dsum_d = (CW+1)'(d_c) + (CW+1)'(r_c);
    end
  end

  // products per axis for both box bounds
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      plo_q[k] <= coef[k] * lo[k];
      phi_q[k] <= coef[k] * hi[k];
    end
    dsum_q <= dsum_d;
  end

  // partial sums: x+y per corner pair, z+offset per z choice
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      xy_q[i] <= SW'((i & 1) != 0 ? phi_q[0] : plo_q[0])
               + SW'((i & 2) != 0 ? phi_q[1] : plo_q[1]);
    end
    zd_q[0] <= SW'(plo_q[2]) + (SW'(dsum_q) <<< FRAC_BITS);
    zd_q[1] <= SW'(phi_q[2]) + (SW'(dsum_q) <<< FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CornerCount; i++) begin
      logic signed [SW-1:0] s;
      s = xy_q[i % 4] + zd_q[i / 4];
      flags_q.nneg[i] <= !s[SW-1];
      flags_q.pos[i]  <= !s[SW-1] && (s != '0);
    end
  end

  assign flags_o = flags_q;

endmodule

// ----- src/frustum_culling_test_unit.sv -----
// result strobe done_o is registered: an accepted test passes through v_q[0], v_q[1], v_q[2] and done_q
// throughput: one request per cycle, busy is always low
// the pipeline has three multiply/add stages plus one reduce stage
// reset clears only the valid bits; planes are undefined until loaded
// the receiver cannot stall, so results are never held back
module frustum_culling_test_unit #(
  parameter int unsigned PLANE_COUNT = 6,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  fct_pkg::req_t req_i,
  output logic          done_o,
  output fct_pkg::rsp_t rsp_o
);
  import fct_pkg::*;

  logic   accept;
  logic   load_we;
  plane_t planes [PLANE_COUNT];
  plane_t wr_plane;
  flags_t flags [PLANE_COUNT];

  logic [2:0] v_q;
  logic [1:0] kind_q [3];
  logic       done_q;
  rsp_t       rsp_q;
  rsp_t       rsp_d;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign load_we = accept && (req_i.command == CMD_LOAD)
                   && (32'(req_i.plane_index) < PLANE_COUNT);
  assign wr_plane = '{a: req_i.vec_x, b: req_i.vec_y, c: req_i.vec_z, d: req_i.vec_w};

  fct_plane_store #(.PLANE_COUNT(PLANE_COUNT)) u_store (
    .clk_i    (clk_i),
    .we_i     (load_we),
    .idx_i    (req_i.plane_index),
    .plane_i  (wr_plane),
    .planes_o (planes)
  );

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    fct_plane_eval #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_eval (
      .clk_i   (clk_i),
      .plane_i (planes[p]),
      .req_i   (req_i),
      .flags_o (flags[p])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      done_q <= 1'b0;
    end else begin
      v_q    <= {v_q[1:0], accept && (req_i.command != CMD_LOAD)};
      done_q <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q[0] <= req_i.command;
    kind_q[1] <= kind_q[0];
    kind_q[2] <= kind_q[1];
    rsp_q     <= rsp_d;
  end

  // reduce plane flags into one inside decision
  always_comb begin
    logic pt_in;
    logic sp_in;
    logic corner_in;
    logic plane_out;
    logic all_pos;
    pt_in     = 1'b1;
    sp_in     = 1'b1;
    corner_in = 1'b0;
    plane_out = 1'b0;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      pt_in = pt_in && flags[p].pos[0];
      sp_in = sp_in && flags[p].nneg[0];
      plane_out = plane_out || (flags[p].nneg == '0);
    end
    for (int i = 0; i < CornerCount; i++) begin
      all_pos = 1'b1;
      for (int p = 0; p < PLANE_COUNT; p++) begin
        all_pos = all_pos && flags[p].pos[i];
      end
      corner_in = corner_in || all_pos;
    end
    rsp_d.test_kind = kind_q[2];
    unique case (kind_q[2])
      CMD_POINT:  rsp_d.inside_res = pt_in;
      CMD_SPHERE: rsp_d.inside_res = sp_in;
      CMD_BOX:    rsp_d.inside_res = corner_in || !plane_out;
      default:    rsp_d.inside_res = 1'b0;
    endcase
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_done_follows_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(v_q[2]))
    else $error("result without request in last stage");

  a_no_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.test_kind != CMD_LOAD))
    else $error("result issued for a load");

  a_test_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.command != CMD_LOAD) |-> ##4 done_o)
    else $error("test request lost");
`endif

endmodule
